// ===== hw/rtl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam int unsigned MAX_OUT = 3;                // results per request
	localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
	localparam int unsigned Q_DEPTH = 4;                // bundle queue entries
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = Q_AW + 1;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;

	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	// Up to three decoded bytes produced by one request.
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b0;
		r.nib = 4'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			r.ok  = 1'b1;
			r.nib = 4'(c - CHAR_0);
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			r.ok  = 1'b1;
			r.nib = 4'(c - CHAR_LA + 8'd10);
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			r.ok  = 1'b1;
			r.nib = 4'(c - CHAR_UA + 8'd10);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/upd_in_if.sv =====
// ----------------------------------------------------------------------------
// upd_in_if
// Encoded byte channel: valid/ready handshake with byte and last flag.
// ----------------------------------------------------------------------------
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/upd_out_if.sv =====
// ----------------------------------------------------------------------------
// upd_out_if
// Decoded byte channel: valid/ready handshake with byte and last flag.
// ----------------------------------------------------------------------------
interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hw/rtl/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder: '+' to space, %XX to the byte it spells.
// ----------------------------------------------------------------------------
// enc carries encoded bytes (in_byte, in_last); dec carries decoded bytes
// (out_byte, out_last). Both use valid/ready; a request moves on a clock edge
// with valid and ready high.
// A request is taken every cycle while the four-entry bundle queue has room.
// Each request yields zero to three decoded bytes; they pass through the
// bundle queue and the output register to dec, one byte per cycle while
// dec is ready. A '%' and its first hex digit are held until the next byte
// settles the escape; the request flagged in_last flushes anything held
// and its final byte carries out_last.
// While dec is ready, sustained rate is one input byte per cycle; a failed
// escape emits up to three bytes, which the queue absorbs while the output
// drains one per cycle. When dec stalls, the output register holds its byte
// and the queue fills; enc.ready drops only once the queue is full.
// Reset clears the escape state, empties the queue and drops dec.valid.
// ----------------------------------------------------------------------------
module url_percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	upd_in_if.sink     enc,
	upd_out_if.source  dec
);

	upd_pkg::push_t     push;
	upd_pkg::bundle_t   head;
	upd_pkg::q_status_t status;
	logic               pop;

	upd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc),
		.status (status),
		.push   (push)
	);

	upd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.status (status)
	);

	upd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (status),
		.pop    (pop),
		.dec    (dec)
	);

	// an accepted last byte always produces at least one result
	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(enc.valid && enc.ready && enc.in_last) |-> push.valid)
		else $error("last request produced no result");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !status.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");

	a_bundle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |-> (head.cnt != '0 && head.cnt <= upd_pkg::CNT_W'(upd_pkg::MAX_OUT)))
		else $error("bad bundle count");

endmodule

// ===== hw/rtl/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks the escape state and builds result bundles.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic                clk,
	input  logic                arst_n,
	upd_in_if.sink              enc,
	input  upd_pkg::q_status_t  status,
	output upd_pkg::push_t      push
);

	upd_pkg::phase_t                               phase_q, phase_n;
	logic [7:0]                                    held_q, held_n;
	upd_pkg::hex_t                                 hx, hh;
	logic [upd_pkg::MAX_OUT-1:0][7:0]              bytes;
	logic [upd_pkg::CNT_W-1:0]                     cnt;
	logic                                          handled;
	logic                                          hold;
	logic                                          acc;

	assign enc.ready = !status.full;
	assign acc       = enc.valid && enc.ready;

	always_comb begin
		hx      = upd_pkg::hex_decode(enc.in_byte);
		hh      = upd_pkg::hex_decode(held_q);
		bytes   = '0;
		cnt     = '0;
		handled = 1'b0;
		hold    = 1'b0;
		phase_n = upd_pkg::PH_NONE;
		held_n  = held_q;
		case (phase_q)
			upd_pkg::PH_PCT: begin
				if (hx.ok && !enc.in_last) begin
					hold    = 1'b1;
					held_n  = enc.in_byte;
					phase_n = upd_pkg::PH_DIGIT;
				end else begin
					bytes[cnt] = upd_pkg::CHAR_PCT;
					cnt        = cnt + 1'b1;
					if (hx.ok) begin
						bytes[cnt] = enc.in_byte;
						cnt        = cnt + 1'b1;
						handled    = 1'b1;
					end
				end
			end
			upd_pkg::PH_DIGIT: begin
				if (hx.ok) begin
					bytes[cnt] = {(hh.ok ? hh.nib : 4'd0), hx.nib};
					cnt        = cnt + 1'b1;
					handled    = 1'b1;
				end else begin
					bytes[cnt] = upd_pkg::CHAR_PCT;
					cnt        = cnt + 1'b1;
					bytes[cnt] = held_q;
					cnt        = cnt + 1'b1;
				end
			end
			default: begin
				phase_n = upd_pkg::PH_NONE;
			end
		endcase
		if (!handled && !hold) begin
			if (enc.in_byte == upd_pkg::CHAR_PLUS) begin
				bytes[cnt] = upd_pkg::CHAR_SPACE;
				cnt        = cnt + 1'b1;
			end else if (enc.in_byte == upd_pkg::CHAR_PCT && !enc.in_last) begin
				phase_n = upd_pkg::PH_PCT;
			end else begin
				bytes[cnt] = enc.in_byte;
				cnt        = cnt + 1'b1;
			end
		end
		if (enc.in_last) begin
			phase_n = upd_pkg::PH_NONE;
		end
	end

	assign push.valid      = acc && (cnt != '0);
	assign push.data.bytes = bytes;
	assign push.data.cnt   = cnt;
	assign push.data.last  = enc.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_NONE;
			held_q  <= 8'd0;
		end else if (acc) begin
			phase_q <= phase_n;
			held_q  <= held_n;
		end
	end

endmodule

// ===== hw/rtl/upd_queue.sv =====
// ----------------------------------------------------------------------------
// upd_queue
// Small FIFO of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module upd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_pkg::push_t     push,
	input  logic               pop,
	output upd_pkg::bundle_t   head,
	output upd_pkg::q_status_t status
);

	upd_pkg::bundle_t            mem_q [upd_pkg::Q_DEPTH];
	logic [upd_pkg::Q_AW-1:0]    wr_q;
	logic [upd_pkg::Q_AW-1:0]    rd_q;
	logic [upd_pkg::Q_CW-1:0]    count_q;
	logic                        do_push;
	logic                        do_pop;

	assign status.full  = (count_q == upd_pkg::Q_CW'(upd_pkg::Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push.valid && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back
// Unpacks queued bundles into single decoded bytes behind an output register.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_pkg::bundle_t   head,
	input  upd_pkg::q_status_t status,
	output logic               pop,
	upd_out_if.source          dec
);

	logic [upd_pkg::CNT_W-1:0] idx_q;
	logic                      vld_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      load;
	logic                      at_end;
	logic [7:0]                cur;

	assign load   = !status.empty && (!vld_q || dec.ready);
	assign at_end = (idx_q == head.cnt - 1'b1);
	assign pop    = load && at_end;

	always_comb begin
		case (idx_q)
			2'd0:    cur = head.bytes[0];
			2'd1:    cur = head.bytes[1];
			default: cur = head.bytes[2];
		endcase
	end

	assign dec.valid    = vld_q;
	assign dec.out_byte = byte_q;
	assign dec.out_last = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur;
			last_q <= head.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= at_end ? '0 : idx_q + 1'b1;
		end else if (dec.ready) begin
			vld_q <= 1'b0;
		end
	end

endmodule
